FILE: src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared constants and item types of the saturating brightness map.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // map geometry
   localparam int MAP_COLS    = 64;
   localparam int MAP_ROWS    = 16;
   localparam int CELL_COUNT  = MAP_COLS * MAP_ROWS;
   localparam int CELL_ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int COUNT_W     = $clog2(CELL_COUNT + 1);

   // field widths
   localparam int CMD_W   = 3;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 4;
   localparam int LEVEL_W = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SAVE    = 3'd4;

   // status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_COORD = 1'b1;

   localparam logic [LEVEL_W-1:0] LIMIT_RESET = 8'hFF;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [LEVEL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] read_value;
      logic               map_clear;
      logic               status;
   } rsp_item_type;

endpackage

FILE: src/saturating_brightness_map.sv
// ----------------------------------------------------------------------------
// saturating_brightness_map
// Byte-per-cell LED brightness store with saturating add, clamped set, get,
// and whole-map restore from / save to a default snapshot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives one
// result, shown on rsp_item for the single cycle that rsp_valid is high; it is
// registered once the item's work ends. The receiver cannot stall, so results
// must be captured as they appear. Add, set and get read the cell from the
// live RAM, and add and set write it back on the following cycle; busy stays
// high until that is done. Out-of-range coordinates and unused commands
// finish in the cycle of acceptance. Restore and save stream the whole map
// from one RAM into the other at one cell per cycle, with busy high until the
// last cell is written. After reset both RAMs are zeroed by a clearing pass
// over all CELL_COUNT cells with busy held high; brightness_limit may be
// written at any time through csr_wr_en / csr_wr_data.
// ----------------------------------------------------------------------------
module saturating_brightness_map (
   input  logic                  clock,
   input  logic                  reset,
   // request items
   input  logic                  start,
   output logic                  busy,
   input  sbm_pkg::req_item_type req_item,
   // result items
   output logic                  rsp_valid,
   output sbm_pkg::rsp_item_type rsp_item,
   // brightness limit register
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_COPY
   } state_type;

   localparam int AW = sbm_pkg::CELL_ADDR_W;
   localparam int CW = sbm_pkg::COUNT_W;
   localparam int LW = sbm_pkg::LEVEL_W;

   // control state
   state_type                   state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic                        clean_ff, clean_in;
   logic [LW-1:0]               limit_ff, limit_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [AW-1:0]               wr_addr_ff, wr_addr_in;
   logic                        save_ff, save_in;
   logic [sbm_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [LW-1:0]               value_ff, value_in;
   sbm_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;

   // RAM ports
   logic          live_wr_en, live_rd_en, dflt_wr_en, dflt_rd_en;
   logic [AW-1:0] live_wr_addr, live_rd_addr, dflt_wr_addr, dflt_rd_addr;
   logic [LW-1:0] live_wr_data, live_rd_data, dflt_wr_data, dflt_rd_data;

   // request decode
   logic          accept;
   logic          in_range;
   logic [AW-1:0] req_addr;
   logic          sweep_last;
   logic          sweep_rd;
   logic          cell_write;

   // cell update
   logic [LW:0]   cell_sum;
   logic [LW-1:0] add_level;
   logic [LW-1:0] set_level;
   logic [LW-1:0] new_level;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = (9'(req_item.col) < 9'(sbm_pkg::MAP_COLS)) &&
                     (9'(req_item.row) < 9'(sbm_pkg::MAP_ROWS));
   // column-major cell index, as the map is laid out in memory
   assign req_addr = AW'(int'(req_item.col) * sbm_pkg::MAP_ROWS + int'(req_item.row));

   assign sweep_last = (cnt_ff == CW'(sbm_pkg::CELL_COUNT));
   assign sweep_rd   = (state_ff == ST_COPY) && !sweep_last;
   assign cell_write = (state_ff == ST_CELL) && (cmd_ff != sbm_pkg::CMD_GET);

   // saturate the 9-bit sum at the limit; a cell above a lowered limit is
   // pulled down by any add
   assign cell_sum  = {1'b0, live_rd_data} + {1'b0, value_ff};
   assign add_level = (cell_sum > {1'b0, limit_ff}) ? limit_ff : cell_sum[LW-1:0];
   assign set_level = (value_ff > limit_ff) ? limit_ff : value_ff;
   assign new_level = (cmd_ff == sbm_pkg::CMD_ADD) ? add_level : set_level;

   // live and default map port control: cell read/modify/write, restore target,
   // save source, clearing pass
   always_comb begin
      live_wr_en   = 1'b0;
      live_wr_addr = cnt_ff[AW-1:0];
      live_wr_data = '0;
      live_rd_en   = 1'b0;
      live_rd_addr = cnt_ff[AW-1:0];
      dflt_wr_en   = 1'b0;
      dflt_wr_addr = cnt_ff[AW-1:0];
      dflt_wr_data = '0;
      dflt_rd_en   = 1'b0;
      dflt_rd_addr = cnt_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            live_wr_en = 1'b1;
            dflt_wr_en = 1'b1;
         end
         ST_IDLE: begin
            live_rd_en   = accept && in_range;
            live_rd_addr = req_addr;
         end
         ST_CELL: begin
            live_wr_en   = cell_write;
            live_wr_addr = addr_ff;
            live_wr_data = new_level;
         end
         ST_COPY: begin
            // read the source one cell ahead, write the target in the next cycle
            live_rd_en   = sweep_rd && save_ff;
            dflt_rd_en   = sweep_rd && !save_ff;
            live_wr_en   = wr_pend_ff && !save_ff;
            live_wr_addr = wr_addr_ff;
            live_wr_data = dflt_rd_data;
            dflt_wr_en   = wr_pend_ff && save_ff;
            dflt_wr_addr = wr_addr_ff;
            dflt_wr_data = live_rd_data;
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      clean_in     = clean_ff;
      save_in      = save_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(sbm_pkg::CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_item.cmd;
               addr_in  = req_addr;
               value_in = req_item.value;
               unique case (req_item.cmd) inside
                  sbm_pkg::CMD_ADD, sbm_pkg::CMD_SET, sbm_pkg::CMD_GET: begin
                     if (in_range) begin
                        state_in = ST_CELL;
                     end else begin
                        // bad coordinate: leave the map alone, report at once
                        rsp_valid_in           = 1'b1;
                        rsp_item_in.read_value = '0;
                        rsp_item_in.map_clear  = clean_ff;
                        rsp_item_in.status     = sbm_pkg::STATUS_BAD_COORD;
                     end
                  end
                  sbm_pkg::CMD_RESTORE, sbm_pkg::CMD_SAVE: begin
                     cnt_in   = '0;
                     save_in  = (req_item.cmd == sbm_pkg::CMD_SAVE);
                     state_in = ST_COPY;
                  end
                  default: begin
                     rsp_valid_in           = 1'b1;
                     rsp_item_in.read_value = '0;
                     rsp_item_in.map_clear  = clean_ff;
                     rsp_item_in.status     = sbm_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_CELL: begin
            // cell data arrived: write back unless get, and report
            rsp_valid_in       = 1'b1;
            rsp_item_in.status = sbm_pkg::STATUS_OK;
            if (cmd_ff == sbm_pkg::CMD_GET) begin
               rsp_item_in.read_value = live_rd_data;
               rsp_item_in.map_clear  = clean_ff;
            end else begin
               clean_in               = 1'b0;
               rsp_item_in.read_value = '0;
               rsp_item_in.map_clear  = 1'b0;
            end
            state_in = ST_IDLE;
         end
         ST_COPY: begin
            if (!sweep_last) begin
               cnt_in     = cnt_ff + CW'(1);
               wr_pend_in = 1'b1;
               wr_addr_in = cnt_ff[AW-1:0];
            end else if (!wr_pend_ff) begin
               // last cell written: both maps agree
               clean_in               = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_item_in.read_value = '0;
               rsp_item_in.map_clear  = 1'b1;
               rsp_item_in.status     = sbm_pkg::STATUS_OK;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         clean_ff     <= 1'b1;
         limit_ff     <= sbm_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wr_pend_ff   <= wr_pend_in;
         clean_ff     <= clean_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_addr_ff   <= wr_addr_in;
         save_ff      <= save_in;
         cmd_ff       <= cmd_in;
         addr_ff      <= addr_in;
         value_ff     <= value_in;
         rsp_item_ff  <= rsp_item_in;
      end
   end

   sbm_ram #(
      .WIDTH (LW),
      .DEPTH (sbm_pkg::CELL_COUNT)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (live_wr_en),
      .wr_addr (live_wr_addr),
      .wr_data (live_wr_data),
      .rd_en   (live_rd_en),
      .rd_addr (live_rd_addr),
      .rd_data (live_rd_data)
   );

   sbm_ram #(
      .WIDTH (LW),
      .DEPTH (sbm_pkg::CELL_COUNT)
   ) u_default_ram (
      .clock   (clock),
      .wr_en   (dflt_wr_en),
      .wr_addr (dflt_wr_addr),
      .wr_data (dflt_wr_data),
      .rd_en   (dflt_rd_en),
      .rd_addr (dflt_rd_addr),
      .rd_data (dflt_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: src/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks on the brightness map, bound to the top level.
// ----------------------------------------------------------------------------
module sbm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input sbm_pkg::rsp_item_type rsp_item
);

   // clearing pass holds off items straight after reset
   a_busy_after_reset : assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // no result without an item taken or work in progress
   a_rsp_has_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result with no item behind it");

   // a bad coordinate is reported in the cycle after acceptance
   a_bad_coord_prompt : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> $past(start && !busy))
      else $error("late out-of-range result");

   // a failed item never returns cell data
   a_bad_coord_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> (rsp_item.read_value == '0))
      else $error("out-of-range result carries data");

endmodule

bind saturating_brightness_map sbm_checker u_sbm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
